FILE: hdl/huffman_tree_walk_decoder_top_macros.svh
// assertion macros for the tree-walk huffman decoder
// used by huffman_tree_walk_decoder_top; no other dependencies
`ifndef HUFFMAN_TREE_WALK_DECODER_TOP_MACROS_SVH
`define HUFFMAN_TREE_WALK_DECODER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define HTWD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("htwd: same-cycle check failed");
`define HTWD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("htwd: next-cycle check failed");
`else
`define HTWD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define HTWD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/htwd_pkg.sv
// shared constants and types for the tree-walk huffman decoder
// used by htwd_tables and huffman_tree_walk_decoder_top
`default_nettype none

package htwd_pkg;

    localparam int SYMBOL_COUNT = 256;
    localparam int ROOT_NODE    = 2 * SYMBOL_COUNT - 2;
    localparam int HEADER_LEN   = SYMBOL_COUNT + 2 * (2 * SYMBOL_COUNT - 1);
    localparam int SYM_W        = 8;
    localparam int NODE_W       = 9;
    localparam int PHASE_W      = 11;
    localparam int CHILD_DEPTH  = 512;
    localparam int CHILD_AW     = 9;
    localparam int LEAF_DEPTH   = 256;
    localparam int LEAF_AW      = 8;
    localparam int SHIFT_W      = 16;
    localparam int COUNT_W      = 5;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_symbol;
        logic       run_end;
    } t_out_beat;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

    typedef struct packed {
        logic                leaf_we;
        logic [LEAF_AW-1:0]  leaf_addr;
        logic [SYM_W-1:0]    leaf_data;
        logic                child_we;
        logic [CHILD_AW-1:0] child_addr;
        logic [NODE_W-1:0]   child_data;
    } t_tbl_wr;

    typedef struct packed {
        logic                child_re;
        logic [CHILD_AW-1:0] child_addr;
        logic                leaf_re;
        logic [LEAF_AW-1:0]  leaf_addr;
    } t_tbl_rd;

endpackage

`default_nettype wire

FILE: hdl/huffman_tree_walk_decoder_top.sv
// header bytes fill the tables; a payload beat that walks n bits stalls the input through
// n child-table reads, the last leaf lookup, the symbol register and the flush
// its last symbol enters the output register at the flush
// results can stall the walk only while the output register is full
// synchronous active-low reset clears control state and sets the walk to the root
// both tables are undefined after reset until the header writes them
`default_nettype none

module huffman_tree_walk_decoder_top (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_stall,
    input  wire  htwd_pkg::t_in_beat  i_data,
    output logic                   o_valid,
    input  wire                    i_stall,
    output htwd_pkg::t_out_beat    o_data
);

`include "huffman_tree_walk_decoder_top_macros.svh"

    htwd_pkg::t_state r_state, n_state;

    logic [htwd_pkg::PHASE_W-1:0] r_phase;
    logic [7:0]                   r_parent_low;
    logic [7:0]                   r_held_first;
    logic [7:0]                   r_held_second;
    logic [1:0]                   r_held_count;
    logic [htwd_pkg::NODE_W-1:0]  r_walk_node;
    logic [htwd_pkg::SHIFT_W-1:0] r_shift;
    logic [htwd_pkg::COUNT_W-1:0] r_bit_count;
    logic                         r_step_last;
    logic                         r_b_valid;
    logic                         r_c_valid;
    logic                         r_pend_valid;
    logic [htwd_pkg::SYM_W-1:0]   r_pend_sym;
    logic                         r_out_valid;
    htwd_pkg::t_out_beat          r_out;

    htwd_pkg::t_tbl_wr            tbl_wr;
    htwd_pkg::t_tbl_rd            tbl_rd;
    logic [htwd_pkg::NODE_W-1:0]  tbl_child_q;
    logic [htwd_pkg::SYM_W-1:0]   tbl_leaf_q;

    logic                         in_acc;
    logic                         advance;
    logic                         is_hdr;
    logic                         is_leaf_ph;
    logic [htwd_pkg::PHASE_W-1:0] hdr_off;
    logic [htwd_pkg::NODE_W-1:0]  hdr_parent;
    logic [htwd_pkg::NODE_W-1:0]  hdr_parent_off;
    logic                         b_is_leaf;
    logic [htwd_pkg::NODE_W-1:0]  b_next;
    logic [htwd_pkg::NODE_W-1:0]  cur_node;
    logic [htwd_pkg::NODE_W-1:0]  cur_off;
    logic [3:0]                   tail_bits;
    logic                         issue_a;
    logic                         issue_leaf;
    logic                         stage_c_go;
    logic                         flush;
    logic                         walk_start;

    htwd_tables u_tables (
        .i_clk     (i_clk),
        .i_wr      (tbl_wr),
        .i_rd      (tbl_rd),
        .o_child_q (tbl_child_q),
        .o_leaf_q  (tbl_leaf_q)
    );

    assign in_acc     = i_valid && !o_stall;
    assign advance    = !r_out_valid || !i_stall;
    assign is_hdr     = r_phase < htwd_pkg::PHASE_W'(htwd_pkg::HEADER_LEN);
    assign is_leaf_ph = r_phase < htwd_pkg::PHASE_W'(htwd_pkg::SYMBOL_COUNT);
    assign hdr_off    = r_phase - htwd_pkg::PHASE_W'(htwd_pkg::SYMBOL_COUNT);
    assign hdr_parent = {i_data.in_byte[0], r_parent_low};
    assign hdr_parent_off = hdr_parent - htwd_pkg::NODE_W'(htwd_pkg::SYMBOL_COUNT);

    assign b_is_leaf = tbl_child_q < htwd_pkg::NODE_W'(htwd_pkg::SYMBOL_COUNT);
    assign b_next    = b_is_leaf ? htwd_pkg::NODE_W'(htwd_pkg::ROOT_NODE) : tbl_child_q;
    assign cur_node  = r_b_valid ? b_next : r_walk_node;
    assign cur_off   = cur_node - htwd_pkg::NODE_W'(htwd_pkg::SYMBOL_COUNT);
    assign tail_bits = (i_data.in_byte > 8'd7) ? 4'd0 : 4'(4'd8 - i_data.in_byte[3:0]);
    assign walk_start = !is_hdr && (i_data.in_last || r_held_count == 2'd2);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            htwd_pkg::ST_IDLE: begin
                if (in_acc && walk_start) begin
                    n_state = htwd_pkg::ST_WALK;
                end
            end
            htwd_pkg::ST_WALK: begin
                if (flush) begin
                    n_state = htwd_pkg::ST_IDLE;
                end
            end
            default: n_state = htwd_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_stall    = 1'b1;
        issue_a    = 1'b0;
        issue_leaf = 1'b0;
        stage_c_go = 1'b0;
        flush      = 1'b0;
        unique case (r_state)
            htwd_pkg::ST_IDLE: begin
                o_stall = 1'b0;
            end
            htwd_pkg::ST_WALK: begin
                issue_a    = advance && (r_bit_count != '0);
                issue_leaf = advance && r_b_valid && b_is_leaf;
                stage_c_go = advance && r_c_valid;
                flush      = advance && (r_bit_count == '0) && !r_b_valid && !r_c_valid;
            end
            default: o_stall = 1'b1;
        endcase
    end

    // table ports
    always_comb begin
        tbl_wr            = '0;
        tbl_wr.leaf_addr  = htwd_pkg::LEAF_AW'(r_phase);
        tbl_wr.leaf_data  = i_data.in_byte;
        tbl_wr.child_addr = htwd_pkg::CHILD_AW'({hdr_parent_off, i_data.in_byte[1]});
        tbl_wr.child_data = htwd_pkg::NODE_W'(hdr_off[htwd_pkg::PHASE_W-1:1]);
        if (in_acc && is_hdr) begin
            if (is_leaf_ph) begin
                tbl_wr.leaf_we = 1'b1;
            end else if (hdr_off[0]) begin
                tbl_wr.child_we =
                    (hdr_parent >= htwd_pkg::NODE_W'(htwd_pkg::SYMBOL_COUNT)) &&
                    (hdr_parent <= htwd_pkg::NODE_W'(htwd_pkg::ROOT_NODE));
            end
        end
        tbl_rd.child_re   = issue_a;
        tbl_rd.child_addr = htwd_pkg::CHILD_AW'({cur_off, r_shift[htwd_pkg::SHIFT_W-1]});
        tbl_rd.leaf_re    = issue_leaf;
        tbl_rd.leaf_addr  = htwd_pkg::LEAF_AW'(tbl_child_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= htwd_pkg::ST_IDLE;
            r_phase       <= '0;
            r_parent_low  <= '0;
            r_held_first  <= '0;
            r_held_second <= '0;
            r_held_count  <= '0;
            r_walk_node   <= htwd_pkg::NODE_W'(htwd_pkg::ROOT_NODE);
            r_bit_count   <= '0;
            r_step_last   <= 1'b0;
            r_b_valid     <= 1'b0;
            r_c_valid     <= 1'b0;
            r_pend_valid  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            // input beat
            if (in_acc) begin
                r_step_last <= i_data.in_last;
                if (i_data.in_last) begin
                    r_phase       <= '0;
                    r_parent_low  <= '0;
                    r_held_first  <= '0;
                    r_held_second <= '0;
                    r_held_count  <= '0;
                    if (!is_hdr) begin
                        r_shift <= {r_held_first, r_held_second};
                        if (r_held_count == 2'd2) begin
                            r_bit_count <= htwd_pkg::COUNT_W'(8) + htwd_pkg::COUNT_W'(tail_bits);
                        end else if (r_held_count == 2'd1) begin
                            r_bit_count <= htwd_pkg::COUNT_W'(tail_bits);
                        end else begin
                            r_bit_count <= '0;
                        end
                    end
                end else if (is_hdr) begin
                    if (!is_leaf_ph && !hdr_off[0]) begin
                        r_parent_low <= i_data.in_byte;
                    end
                    r_phase <= r_phase + 1'b1;
                end else begin
                    if (r_held_count == 2'd0) begin
                        r_held_first <= i_data.in_byte;
                        r_held_count <= 2'd1;
                    end else if (r_held_count == 2'd1) begin
                        r_held_second <= i_data.in_byte;
                        r_held_count  <= 2'd2;
                    end else begin
                        r_shift       <= {r_held_first, 8'd0};
                        r_bit_count   <= htwd_pkg::COUNT_W'(8);
                        r_held_first  <= r_held_second;
                        r_held_second <= i_data.in_byte;
                    end
                end
            end

            // bit issue
            if (issue_a) begin
                r_shift     <= {r_shift[htwd_pkg::SHIFT_W-2:0], 1'b0};
                r_bit_count <= r_bit_count - 1'b1;
            end
            if (advance && r_state == htwd_pkg::ST_WALK) begin
                r_b_valid <= issue_a;
                r_c_valid <= issue_leaf;
            end

            // child read back
            if (advance && r_b_valid && r_state == htwd_pkg::ST_WALK) begin
                r_walk_node <= b_next;
            end

            // symbol held one deep so the run end can be marked
            if (stage_c_go) begin
                r_pend_sym   <= tbl_leaf_q;
                r_pend_valid <= 1'b1;
            end
            if (flush) begin
                r_pend_valid <= 1'b0;
                if (r_step_last) begin
                    r_walk_node <= htwd_pkg::NODE_W'(htwd_pkg::ROOT_NODE);
                end
            end

            // output register
            if ((stage_c_go || flush) && r_pend_valid) begin
                r_out_valid      <= 1'b1;
                r_out.out_symbol <= r_pend_sym;
                r_out.run_end    <= flush;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `HTWD_ASSERT_IMPL(a_idle_drained, i_clk, i_rst_n, r_state == htwd_pkg::ST_IDLE,
        !r_b_valid && !r_c_valid && !r_pend_valid && r_bit_count == '0)
    `HTWD_ASSERT_IMPL(a_count_range, i_clk, i_rst_n, r_state == htwd_pkg::ST_WALK,
        r_bit_count <= htwd_pkg::COUNT_W'(16))
    `HTWD_ASSERT_NEXT(a_last_rearm, i_clk, i_rst_n, flush && r_step_last,
        r_walk_node == htwd_pkg::NODE_W'(htwd_pkg::ROOT_NODE) && r_held_count == 2'd0 && r_phase == '0)

endmodule

`default_nettype wire

FILE: hdl/htwd_tables.sv
// leaf-to-symbol table and child table, one write and one registered read each
// depends on htwd_pkg
`default_nettype none

module htwd_tables (
    input  wire                              i_clk,
    input  wire  htwd_pkg::t_tbl_wr          i_wr,
    input  wire  htwd_pkg::t_tbl_rd          i_rd,
    output logic [htwd_pkg::NODE_W-1:0]      o_child_q,
    output logic [htwd_pkg::SYM_W-1:0]       o_leaf_q
);

    logic [htwd_pkg::NODE_W-1:0] r_child_mem [htwd_pkg::CHILD_DEPTH];
    logic [htwd_pkg::SYM_W-1:0]  r_leaf_mem  [htwd_pkg::LEAF_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr.child_we) begin
            r_child_mem[i_wr.child_addr] <= i_wr.child_data;
        end
        if (i_rd.child_re) begin
            o_child_q <= r_child_mem[i_rd.child_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.leaf_we) begin
            r_leaf_mem[i_wr.leaf_addr] <= i_wr.leaf_data;
        end
        if (i_rd.leaf_re) begin
            o_leaf_q <= r_leaf_mem[i_rd.leaf_addr];
        end
    end

endmodule

`default_nettype wire
